>>> hw/rtl/scma_pkg.sv
`default_nettype none

package scma_pkg;

  // Fixed field widths of the command and result ports.
  localparam int unsigned CHAN_W         = 3;
  localparam int unsigned SAMPLE_FIELD_W = 10;
  localparam int unsigned SAMPLE_FIELDS  = 6;
  localparam int unsigned AVG_W          = 10;

  // Function codes.
  localparam logic FUNC_CAPTURE = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  // Access request to the sample ring for the current transaction.
  typedef struct packed {
    logic rd;
    logic wr;
  } scma_ring_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/six_channel_moving_average.sv
`default_nettype none

// Boxcar moving average over CHANNELS converter channels and the last WINDOW
// captures. A capture transaction (func 0) reads the ring slot about to be
// overwritten from the registered sample memory on acceptance, then in ST_CAP
// writes the new samples and updates every running sum. A read transaction
// (func 1) passes through ST_MUL, which scales the running sum of the channel
// by a constant reciprocal into a product register, then ST_RES, which shows
// the result with done_o high for exactly one cycle. busy is high from
// the cycle after acceptance until the transaction ends, and the receiver
// cannot stall the result. Averages count zeros until WINDOW captures have
// been made, and a read of a nonexistent channel returns an average of zero.
module six_channel_moving_average #(
  parameter int unsigned CHANNELS    = 6,
  parameter int unsigned WINDOW      = 16,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  func_i,
  input  wire logic [scma_pkg::CHAN_W-1:0]           channel_i,
  input  wire logic [scma_pkg::SAMPLE_FIELD_W-1:0]   sample_ch0_i,
  input  wire logic [scma_pkg::SAMPLE_FIELD_W-1:0]   sample_ch1_i,
  input  wire logic [scma_pkg::SAMPLE_FIELD_W-1:0]   sample_ch2_i,
  input  wire logic [scma_pkg::SAMPLE_FIELD_W-1:0]   sample_ch3_i,
  input  wire logic [scma_pkg::SAMPLE_FIELD_W-1:0]   sample_ch4_i,
  input  wire logic [scma_pkg::SAMPLE_FIELD_W-1:0]   sample_ch5_i,
  output logic                                       done_o,
  output logic      [scma_pkg::CHAN_W-1:0]           read_channel_o,
  output logic      [scma_pkg::AVG_W-1:0]            average_o
);

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned DATA_W = CHANNELS * SAMPLE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAP,
    ST_MUL,
    ST_RES
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   accept;

  logic [scma_pkg::SAMPLE_FIELD_W-1:0] fields [scma_pkg::SAMPLE_FIELDS];
  logic [DATA_W-1:0]                   samp_d, samp_q;
  logic [scma_pkg::CHAN_W-1:0]         chan_q;
  logic [SUM_W-1:0]                    sums_q [CHANNELS];
  logic [SUM_W-1:0]                    sel_sum;
  logic [DATA_W-1:0]                   old_samp;
  logic [SAMPLE_BITS-1:0]              quot;
  scma_pkg::scma_ring_ctl_t            ring_ctl;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign fields[0] = sample_ch0_i;
  assign fields[1] = sample_ch1_i;
  assign fields[2] = sample_ch2_i;
  assign fields[3] = sample_ch3_i;
  assign fields[4] = sample_ch4_i;
  assign fields[5] = sample_ch5_i;

  // Channels beyond the six sample ports always capture zero.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_samp
    if (c < scma_pkg::SAMPLE_FIELDS) begin : g_field
      assign samp_d[c*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(fields[c]);
    end else begin : g_zero
      assign samp_d[c*SAMPLE_BITS +: SAMPLE_BITS] = '0;
    end
  end

  always_comb begin
    ring_ctl.rd = accept && (func_i == scma_pkg::FUNC_CAPTURE);
    ring_ctl.wr = (state_q == ST_CAP);
  end

  scma_ring #(
    .WINDOW (WINDOW),
    .DATA_W (DATA_W)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ring_ctl),
    .wdata_i (samp_q),
    .rdata_o (old_samp)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= samp_d;
      chan_q <= channel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == ST_MUL);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (func_i == scma_pkg::FUNC_CAPTURE) ? ST_CAP : ST_MUL;
          end
        end
        ST_CAP:  state_q <= ST_IDLE;
        ST_MUL:  state_q <= ST_RES;
        ST_RES:  state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The replaced sample leaves the sum as the new one enters it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sums_q[c] <= '0;
      end
    end else if (state_q == ST_CAP) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sums_q[c] <= sums_q[c]
                     - SUM_W'(old_samp[c*SAMPLE_BITS +: SAMPLE_BITS])
                     + SUM_W'(samp_q[c*SAMPLE_BITS +: SAMPLE_BITS]);
      end
    end
  end

  // A channel number with no sum selects zero.
  always_comb begin
    sel_sum = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(chan_q) == c) begin
        sel_sum = sums_q[c];
      end
    end
  end

  scma_avg #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_avg (
    .clk_i  (clk_i),
    .load_i (state_q == ST_MUL),
    .sum_i  (sel_sum),
    .quot_o (quot)
  );

  assign done_o         = done_q;
  assign read_channel_o = chan_q;
  assign average_o      = scma_pkg::AVG_W'(quot);

endmodule

`default_nettype wire

>>> hw/rtl/scma_ring.sv
`default_nettype none

module scma_ring #(
  parameter int unsigned WINDOW = 16,
  parameter int unsigned DATA_W = 60
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire scma_pkg::scma_ring_ctl_t ctl_i,
  input  wire logic [DATA_W-1:0]       wdata_i,
  output logic      [DATA_W-1:0]       rdata_o
);

  localparam int unsigned PTR_W = $clog2(WINDOW);

  logic [DATA_W-1:0] mem_q [WINDOW];
  logic [DATA_W-1:0] rd_data_q;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic              filled_q;
  logic              rd_live_q;

  assign ptr_d = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[ptr_q] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem_q[ptr_q];
    end
  end

  // Slots are written strictly in order, so until the pointer first wraps
  // the slot under it has never been written and reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      filled_q  <= 1'b0;
      rd_live_q <= 1'b0;
    end else begin
      if (ctl_i.rd) begin
        rd_live_q <= filled_q;
      end
      if (ctl_i.wr) begin
        ptr_q <= ptr_d;
        if (ptr_q == PTR_W'(WINDOW - 1)) begin
          filled_q <= 1'b1;
        end
      end
    end
  end

  assign rdata_o = rd_live_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/scma_avg.sv
`default_nettype none

module scma_avg #(
  parameter int unsigned WINDOW      = 16,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         load_i,
  input  wire logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]        sum_i,
  output logic      [SAMPLE_BITS-1:0]                       quot_o
);

  localparam int unsigned WIN_LOG = $clog2(WINDOW);
  localparam int unsigned SUM_W   = SAMPLE_BITS + WIN_LOG;
  localparam int unsigned PROD_W  = 2 * SUM_W + 1;
  localparam int unsigned SHIFT   = SUM_W + WIN_LOG;

  // floor(2^SHIFT / WINDOW) + 1 gives an exact quotient for every sum
  // below 2^SUM_W, also when the window is a power of two.
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / 64'(WINDOW)) + 64'd1;
  localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

  logic [PROD_W-1:0] product_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      product_q <= PROD_W'(sum_i) * PROD_W'(RECIP);
    end
  end

  assign quot_o = product_q[SHIFT +: SAMPLE_BITS];

endmodule

`default_nettype wire

>>> bench/tb_six_channel_moving_average.sv
`default_nettype none

module tb_six_channel_moving_average;

  localparam int unsigned NUM_CHANNELS = 6;
  localparam int unsigned WINDOW = 16;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic                                                         func;
    logic [scma_pkg::CHAN_W-1:0]                                  chan;
    logic [scma_pkg::SAMPLE_FIELDS-1:0][scma_pkg::SAMPLE_FIELD_W-1:0] smp;
    logic                                                         fixed;
    logic [scma_pkg::AVG_W-1:0]                                   fixed_avg;
  } avg_cmd_t;

  typedef struct packed {
    logic [scma_pkg::CHAN_W-1:0] chan;
    logic [scma_pkg::AVG_W-1:0]  avg;
  } avg_result_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic                                func_i = scma_pkg::FUNC_CAPTURE;
  logic [scma_pkg::CHAN_W-1:0]         channel_i = '0;
  logic [scma_pkg::SAMPLE_FIELD_W-1:0] sample_ch0_i = '0;
  logic [scma_pkg::SAMPLE_FIELD_W-1:0] sample_ch1_i = '0;
  logic [scma_pkg::SAMPLE_FIELD_W-1:0] sample_ch2_i = '0;
  logic [scma_pkg::SAMPLE_FIELD_W-1:0] sample_ch3_i = '0;
  logic [scma_pkg::SAMPLE_FIELD_W-1:0] sample_ch4_i = '0;
  logic [scma_pkg::SAMPLE_FIELD_W-1:0] sample_ch5_i = '0;
  logic                                done_o;
  logic [scma_pkg::CHAN_W-1:0]         read_channel_o;
  logic [scma_pkg::AVG_W-1:0]          average_o;

  // Typed-in expectation that travels with the transaction being offered.
  logic                                fixed_valid = 1'b0;
  logic [scma_pkg::AVG_W-1:0]          fixed_avg = '0;

  logic [scma_pkg::SAMPLE_FIELD_W-1:0] sample_ring [WINDOW][NUM_CHANNELS];
  logic [3:0]                          write_slot;
  logic [13:0]                         channel_sums [NUM_CHANNELS];
  avg_result_t                         pending_averages [$];

  int unsigned                         error_count = 0;
  int unsigned                         cycle_count = 0;
  int unsigned                         burst_left = 0;
  avg_cmd_t                            directed_rows [$];

  six_channel_moving_average dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .channel_i      (channel_i),
    .sample_ch0_i   (sample_ch0_i),
    .sample_ch1_i   (sample_ch1_i),
    .sample_ch2_i   (sample_ch2_i),
    .sample_ch3_i   (sample_ch3_i),
    .sample_ch4_i   (sample_ch4_i),
    .sample_ch5_i   (sample_ch5_i),
    .done_o         (done_o),
    .read_channel_o (read_channel_o),
    .average_o      (average_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic void clear_averager();
    for (int s = 0; s < WINDOW; s++) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sample_ring[s][c] = '0;
      end
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      channel_sums[c] = '0;
    end
    write_slot = '0;
  endfunction

  // The oldest sample leaves each running sum as the new one enters it.
  function automatic void store_capture(
    input logic [scma_pkg::SAMPLE_FIELDS-1:0][scma_pkg::SAMPLE_FIELD_W-1:0] smp
  );
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      channel_sums[c] = channel_sums[c] - 14'(sample_ring[write_slot][c]) + 14'(smp[c]);
      sample_ring[write_slot][c] = smp[c];
    end
    write_slot = (write_slot == 4'(WINDOW - 1)) ? 4'd0 : write_slot + 4'd1;
  endfunction

  function automatic logic [scma_pkg::AVG_W-1:0] boxcar_average(
    input logic [scma_pkg::CHAN_W-1:0] chan
  );
    if (chan >= scma_pkg::CHAN_W'(NUM_CHANNELS)) begin
      return '0;
    end
    return scma_pkg::AVG_W'(channel_sums[chan] / WINDOW);
  endfunction

  function automatic avg_cmd_t make_cmd(
    input logic                                                         func,
    input logic [scma_pkg::CHAN_W-1:0]                                  chan,
    input logic [scma_pkg::SAMPLE_FIELDS-1:0][scma_pkg::SAMPLE_FIELD_W-1:0] smp,
    input logic                                                         fixed,
    input logic [scma_pkg::AVG_W-1:0]                                   favg
  );
    avg_cmd_t cmd;
    cmd.func = func;
    cmd.chan = chan;
    cmd.smp = smp;
    cmd.fixed = fixed;
    cmd.fixed_avg = favg;
    return cmd;
  endfunction

  // Offer one transaction and hold it until the block takes it, then either
  // follow straight on or drop start for a random gap between bursts.
  task automatic send_cmd(input avg_cmd_t cmd);
    start <= 1'b1;
    func_i <= cmd.func;
    channel_i <= cmd.chan;
    sample_ch0_i <= cmd.smp[0];
    sample_ch1_i <= cmd.smp[1];
    sample_ch2_i <= cmd.smp[2];
    sample_ch3_i <= cmd.smp[3];
    sample_ch4_i <= cmd.smp[4];
    sample_ch5_i <= cmd.smp[5];
    fixed_valid <= cmd.fixed;
    fixed_avg <= cmd.fixed_avg;
    do begin
      @(posedge clk_i);
    end while (busy);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
      start <= 1'b0;
      fixed_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[six_channel_moving_average] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_averages.size() == 0) begin
          note_error($sformatf("unexpected result channel %0d average %0d",
                               read_channel_o, average_o));
        end else begin
          avg_result_t want;
          want = pending_averages.pop_front();
          if (read_channel_o !== want.chan) begin
            note_error($sformatf("read_channel expected %0d actual %0d",
                                 want.chan, read_channel_o));
          end
          if (average_o !== want.avg) begin
            note_error($sformatf("average of channel %0d expected %0d actual %0d",
                                 want.chan, want.avg, average_o));
          end
        end
      end
      if (start && !busy) begin
        if (func_i == scma_pkg::FUNC_CAPTURE) begin
          store_capture({sample_ch5_i, sample_ch4_i, sample_ch3_i,
                         sample_ch2_i, sample_ch1_i, sample_ch0_i});
        end else begin
          avg_result_t got;
          got.chan = channel_i;
          got.avg = fixed_valid ? fixed_avg : boxcar_average(channel_i);
          pending_averages.push_back(got);
        end
      end
    end
  end

  initial begin
    avg_cmd_t cmd;
    int unsigned mode;
    logic [scma_pkg::SAMPLE_FIELDS-1:0][scma_pkg::SAMPLE_FIELD_W-1:0] zeros;
    logic [scma_pkg::SAMPLE_FIELDS-1:0][scma_pkg::SAMPLE_FIELD_W-1:0] full;

    zeros = '0;
    full = {scma_pkg::SAMPLE_FIELDS{10'd1023}};
    clear_averager();

    // Reads right after reset see the cleared sums; channels six and seven
    // do not exist and always report zero.
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd0, zeros, 1'b1, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd5, full, 1'b1, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd6, zeros, 1'b1, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd7, full, 1'b1, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_CAPTURE, 3'd0, full, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd0, zeros, 1'b1, 10'd63));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd5, zeros, 1'b1, 10'd63));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd7, zeros, 1'b1, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_CAPTURE, 3'd7, zeros, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd2, zeros, 1'b1, 10'd63));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_CAPTURE, 3'd2,
      {10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155}, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_CAPTURE, 3'd5,
      {10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA}, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_CAPTURE, 3'd1,
      {10'd1023, 10'd512, 10'd8, 10'd4, 10'd2, 10'd1}, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd1, zeros, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd3, full, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd4, zeros, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_CAPTURE, 3'd6,
      {10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023}, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd0, zeros, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd5, zeros, 1'b0, 10'd0));
    directed_rows.push_back(make_cmd(scma_pkg::FUNC_READ, 3'd6, full, 1'b1, 10'd0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i]);
    end

    // Stretches of full-scale and of zero samples drive the window to its
    // extremes and through many wraps of the slot pointer.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ((n % 300) < 45) begin
        mode = 1;
      end else if ((n % 300) >= 150 && (n % 300) < 195) begin
        mode = 0;
      end else begin
        mode = $urandom_range(0, 9);
      end
      cmd = '0;
      cmd.func = ($urandom_range(0, 99) < 55) ? scma_pkg::FUNC_CAPTURE : scma_pkg::FUNC_READ;
      cmd.chan = scma_pkg::CHAN_W'($urandom_range(0, 7));
      for (int c = 0; c < scma_pkg::SAMPLE_FIELDS; c++) begin
        case (mode)
          0: cmd.smp[c] = '0;
          1: cmd.smp[c] = 10'd1023;
          default: cmd.smp[c] = scma_pkg::SAMPLE_FIELD_W'($urandom_range(0, 1023));
        endcase
      end
      send_cmd(cmd);
    end

    start <= 1'b0;
    fixed_valid <= 1'b0;
    while (pending_averages.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_averages.size() != 0) begin
      note_error($sformatf("%0d expected results never arrived", pending_averages.size()));
    end

    if (error_count == 0) begin
      $display("[six_channel_moving_average] OK");
    end else begin
      $display("[six_channel_moving_average] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
